// ----- hdl/mfr_pkg.sv -----
// Package for the Muskingum flow routing block: widths, register indexes,
// the microcode word and its program, and the saturation helpers.
// No dependencies.
`default_nettype none

package mfr_pkg;

  // Flow and coefficient formats.
  localparam int FLOW_W   = 32;
  localparam int COEF_W   = 16;
  localparam int FRAC_W   = COEF_W - 2;

  // Configuration register widths and port shape.
  localparam int TIME_W     = 16;
  localparam int REACH_W    = 24;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REACH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd2;

  localparam logic [TIME_W-1:0]   INTERVAL_RST = 16'd1;
  localparam logic [REACH_W-1:0]  REACH_RST    = 24'd4;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 16'd13107;

  // T is scaled by 2^18 and the reach by 2^17 so that both line up with 2*L*x.
  localparam int T_SHIFT = 18;
  localparam int K_SHIFT = 17;

  // Shared multiplier: signed 33 x 17 bits.
  localparam int MUL_A_W = FLOW_W + 1;
  localparam int MUL_B_W = COEF_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;

  // Coefficient divider: numerator and denominator below 2^42.
  localparam int DIV_W    = 42;
  localparam int REM_W    = DIV_W + 1;
  localparam int CMP_W    = REM_W + 1;
  localparam int DCNT_W   = 5;
  // Range check, integer bit, FRAC_W fraction bits and one rounding bit.
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(FRAC_W + 3);
  localparam logic [DCNT_W-1:0] DIV_INT   = DCNT_W'(FRAC_W + 2);
  localparam logic [DCNT_W-1:0] DIV_RND   = DCNT_W'(1);

  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << FRAC_W);
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

  // Microcode sequencer.
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_WAIT     = 4'd0;
  localparam step_t S_CHECK    = 4'd1;
  localparam step_t S_MUL_LX   = 4'd2;
  localparam step_t S_SETUP    = 4'd3;
  localparam step_t S_LOAD_C0  = 4'd4;
  localparam step_t S_DIV_C0   = 4'd5;
  localparam step_t S_STORE_C0 = 4'd6;
  localparam step_t S_DIV_C1   = 4'd7;
  localparam step_t S_STORE_C1 = 4'd8;
  localparam step_t S_FIRST    = 4'd9;
  localparam step_t S_MAC0     = 4'd10;
  localparam step_t S_MAC1     = 4'd11;
  localparam step_t S_MAC2     = 4'd12;
  localparam step_t S_MAC3     = 4'd13;
  localparam step_t S_ROUND    = 4'd14;
  localparam step_t S_OUTLET   = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL_LX,
    OP_SETUP,
    OP_LOAD_C0,
    OP_DIV_STEP,
    OP_STORE_C0,
    OP_STORE_C1,
    OP_FIRST,
    OP_MUL_C0,
    OP_MUL_C1,
    OP_MUL_C2,
    OP_ACC,
    OP_ROUND,
    OP_OUTLET
  } op_t;

  typedef enum logic [2:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_NO_ACCEPT,
    BR_NOT_START,
    BR_DZERO,
    BR_DIV_BUSY,
    BR_OUT_BUSY
  } br_t;

  typedef struct packed {
    op_t   op;
    br_t   br;
    step_t target;
  } uword_t;

  // The program. A branch that is not taken falls through to the next step;
  // the step after the outlet step wraps back to the wait step.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    case (s)
      S_WAIT:     w = '{OP_ACCEPT,   BR_NO_ACCEPT, S_WAIT};
      S_CHECK:    w = '{OP_NOP,      BR_NOT_START, S_MAC0};
      S_MUL_LX:   w = '{OP_MUL_LX,   BR_NEVER,     S_WAIT};
      S_SETUP:    w = '{OP_SETUP,    BR_DZERO,     S_FIRST};
      S_LOAD_C0:  w = '{OP_LOAD_C0,  BR_NEVER,     S_WAIT};
      S_DIV_C0:   w = '{OP_DIV_STEP, BR_DIV_BUSY,  S_DIV_C0};
      S_STORE_C0: w = '{OP_STORE_C0, BR_NEVER,     S_WAIT};
      S_DIV_C1:   w = '{OP_DIV_STEP, BR_DIV_BUSY,  S_DIV_C1};
      S_STORE_C1: w = '{OP_STORE_C1, BR_NEVER,     S_WAIT};
      S_FIRST:    w = '{OP_FIRST,    BR_ALWAYS,    S_OUTLET};
      S_MAC0:     w = '{OP_MUL_C0,   BR_NEVER,     S_WAIT};
      S_MAC1:     w = '{OP_MUL_C1,   BR_NEVER,     S_WAIT};
      S_MAC2:     w = '{OP_MUL_C2,   BR_NEVER,     S_WAIT};
      S_MAC3:     w = '{OP_ACC,      BR_NEVER,     S_WAIT};
      S_ROUND:    w = '{OP_ROUND,    BR_NEVER,     S_WAIT};
      S_OUTLET:   w = '{OP_OUTLET,   BR_OUT_BUSY,  S_OUTLET};
      default:    w = '{OP_NOP,      BR_ALWAYS,    S_WAIT};
    endcase
    return w;
  endfunction

  // Saturation of a wide signed value to the flow range.
  localparam logic signed [ACC_W-1:0] FLOW_MAX =
    {{(ACC_W - FLOW_W + 1){1'b0}}, {(FLOW_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] FLOW_MIN = ~FLOW_MAX;

  function automatic logic flow_clip(input logic signed [ACC_W-1:0] v);
    return (v > FLOW_MAX) || (v < FLOW_MIN);
  endfunction

  function automatic logic [FLOW_W-1:0] flow_sat(input logic signed [ACC_W-1:0] v);
    logic [FLOW_W-1:0] r;
    if (v > FLOW_MAX) begin
      r = FLOW_MAX[FLOW_W-1:0];
    end else if (v < FLOW_MIN) begin
      r = FLOW_MIN[FLOW_W-1:0];
    end else begin
      r = v[FLOW_W-1:0];
    end
    return r;
  endfunction

  // Saturation of a coefficient candidate to signed Q2.FRAC_W.
  localparam logic signed [COEF_W+1:0] COEF_MAX =
    {3'b000, {(COEF_W - 1){1'b1}}};
  localparam logic signed [COEF_W+1:0] COEF_MIN = ~COEF_MAX;

  function automatic logic [COEF_W-1:0] coef_clamp(input logic signed [COEF_W+1:0] v);
    logic [COEF_W-1:0] r;
    if (v > COEF_MAX) begin
      r = COEF_MAX[COEF_W-1:0];
    end else if (v < COEF_MIN) begin
      r = COEF_MIN[COEF_W-1:0];
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/muskingum_flow_routing.sv -----
// Muskingum flow routing: a microcoded sequencer over one shared multiplier,
// one shift-subtract divider and the flow accumulator.
// Depends on mfr_pkg.
//
//   Channel | Ports                        | Carries
//   --------+------------------------------+------------------------------------------
//   input   | in_tvalid/in_tready          | in_tdata: three flows; in_tlast: last
//   result  | out_tvalid/out_tready        | out_tdata: routed flow; out_tuser: clip
//   config  | cfg_valid/cfg_ready          | cfg_index, cfg_data (always ready)
//
// An item inside a series holds the sequencer through the wait, check, MAC0 to MAC3,
// round and outlet steps, and its result register loads at the outlet step; the
// multiply-accumulate steps on the single shared multiplier set this length.
// An item that starts a series holds it longer, mostly for the two 17-step divisions
// for c0 and c1, which are skipped when the denominator is zero, as it is when
// interval and reach are both zero.
// The next item is accepted as soon as the program is back at its wait step, even
// while the previous result waits; the outlet step stalls only on a full output.
// Reset is synchronous and active low and restores the register defaults.
`default_nettype none

module muskingum_flow_routing
  import mfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [31:0] upstream_flow_a, [63:32] upstream_flow_b, [95:64] local_runoff
  input  wire logic [3*FLOW_W-1:0]   in_tdata,
  input  wire logic                  in_tlast,   // last_in_series

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] routed_flow
  output logic [FLOW_W-1:0]          out_tdata,
  // [0] saturated
  output logic                       out_tuser,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Sequencer.
  step_t  step_r, step_nxt;
  uword_t uw;
  logic   taken;
  logic   in_acc;
  logic   out_busy;

  // Configuration.
  logic [TIME_W-1:0]   interval_r;
  logic [REACH_W-1:0]  reach_r;
  logic [WEIGHT_W-1:0] weight_r;

  // Routing state.
  logic signed [FLOW_W-1:0] prev_in_r, prev_out_r;
  logic signed [COEF_W-1:0] c0_r, c1_r, c2_r;
  logic                     start_r;

  // Per-item registers.
  logic signed [FLOW_W-1:0] inflow_r, runoff_r, routed_r;
  logic                     last_r, clip_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  // Coefficient setup and divider.
  logic [DIV_W-1:0]        ak_r, den_r, apb_r;
  logic signed [DIV_W:0]   diff_r;
  logic [REM_W-1:0]        rem_r;
  logic [COEF_W-1:0]       q_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic                    neg_r, sat_r;

  // Output register.
  logic              out_valid_r, out_user_r;
  logic [FLOW_W-1:0] out_data_r;

  // Combinational datapath.
  logic signed [FLOW_W-1:0]  fa, fb, fl;
  logic signed [FLOW_W:0]    in_sum, out_sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_w;
  logic [DIV_W-1:0]          t_scaled, k_scaled, b_w, d_w;
  logic                      d_zero;
  logic signed [DIV_W:0]     diff_neg;
  logic [DIV_W-1:0]          num_c0;
  logic                      div_first, div_int, div_rnd, ge;
  logic [CMP_W-1:0]          lhs, rhs, dsub;
  logic signed [COEF_W:0]    mag, qs;
  logic [COEF_W-1:0]         div_coef;
  logic signed [COEF_W+1:0]  c2_sum;
  logic signed [ACC_W-1:0]   acc_shr;

  assign uw        = ucode_rom(step_r);
  assign in_tready = (uw.op == OP_ACCEPT);
  assign in_acc    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign fa = in_tdata[FLOW_W-1:0];
  assign fb = in_tdata[2*FLOW_W-1:FLOW_W];
  assign fl = in_tdata[3*FLOW_W-1:2*FLOW_W];
  assign in_sum  = (FLOW_W + 1)'(fa) + (FLOW_W + 1)'(fb);
  assign out_sum = (FLOW_W + 1)'(routed_r) + (FLOW_W + 1)'(runoff_r);

  // Shared multiplier operands.
  always_comb begin
    case (uw.op)
      OP_MUL_LX: begin
        mul_a = MUL_A_W'(reach_r);
        mul_b = MUL_B_W'(weight_r);
      end
      OP_MUL_C0: begin
        mul_a = MUL_A_W'(inflow_r);
        mul_b = MUL_B_W'(c0_r);
      end
      OP_MUL_C1: begin
        mul_a = MUL_A_W'(prev_in_r);
        mul_b = MUL_B_W'(c1_r);
      end
      OP_MUL_C2: begin
        mul_a = MUL_A_W'(prev_out_r);
        mul_b = MUL_B_W'(c2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_w = mul_a * mul_b;

  // Coefficient terms: a = T*2^18, k = L*2^17, b = 2*L*x, D = a + k - b.
  assign t_scaled = DIV_W'(interval_r) << T_SHIFT;
  assign k_scaled = DIV_W'(reach_r) << K_SHIFT;
  assign b_w      = {prod_r[DIV_W-2:0], 1'b0};
  assign d_w      = ak_r - b_w;
  assign d_zero   = (d_w == '0);
  assign diff_neg = -diff_r;
  assign num_c0   = diff_r[DIV_W] ? diff_neg[DIV_W-1:0] : diff_r[DIV_W-1:0];

  // One divider step: range check against 2D, then the integer bit,
  // the fraction bits and finally the rounding bit.
  assign div_first = (dcnt_r == DIV_STEPS);
  assign div_int   = (dcnt_r == DIV_INT);
  assign div_rnd   = (dcnt_r == DIV_RND);
  assign lhs  = (div_first || div_int) ? CMP_W'(rem_r) : {rem_r, 1'b0};
  assign rhs  = div_first ? {1'b0, den_r, 1'b0} : CMP_W'(den_r);
  assign ge   = (lhs >= rhs);
  assign dsub = lhs - rhs;

  assign mag      = sat_r ? (COEF_W + 1)'(1 << (COEF_W - 1)) : (COEF_W + 1)'(q_r);
  assign qs       = neg_r ? -mag : mag;
  assign div_coef = coef_clamp((COEF_W + 2)'(qs));
  assign c2_sum   = (COEF_W + 2)'(COEF_ONE) - (COEF_W + 2)'(c0_r)
                  - (COEF_W + 2)'($signed(div_coef));

  assign acc_shr = acc_r >>> FRAC_W;

  always_comb begin
    case (uw.br)
      BR_NEVER:     taken = 1'b0;
      BR_ALWAYS:    taken = 1'b1;
      BR_NO_ACCEPT: taken = !in_acc;
      BR_NOT_START: taken = !start_r;
      BR_DZERO:     taken = d_zero;
      BR_DIV_BUSY:  taken = (dcnt_r > DIV_RND);
      BR_OUT_BUSY:  taken = out_busy;
      default:      taken = 1'b0;
    endcase
    step_nxt = taken ? uw.target : step_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_WAIT;
      interval_r  <= INTERVAL_RST;
      reach_r     <= REACH_RST;
      weight_r    <= WEIGHT_RST;
      prev_in_r   <= '0;
      prev_out_r  <= '0;
      c0_r        <= '0;
      c1_r        <= '0;
      c2_r        <= '0;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      step_r <= step_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          REG_INTERVAL: interval_r <= cfg_data[TIME_W-1:0];
          REG_REACH:    reach_r    <= cfg_data[REACH_W-1:0];
          REG_WEIGHT:   weight_r   <= cfg_data[WEIGHT_W-1:0];
          default:      ;
        endcase
      end

      // A new result word may be loaded in the cycle the old one drains.
      if (uw.op == OP_OUTLET && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (uw.op)
        OP_ACCEPT: begin
          if (in_acc) begin
            inflow_r <= flow_sat(ACC_W'(in_sum));
            clip_r   <= flow_clip(ACC_W'(in_sum));
            runoff_r <= fl;
            last_r   <= in_tlast;
          end
        end
        OP_MUL_LX: begin
          prod_r <= prod_w;
          ak_r   <= t_scaled + k_scaled;
        end
        OP_SETUP: begin
          den_r  <= d_w;
          diff_r <= $signed({1'b0, t_scaled}) - $signed({1'b0, b_w});
          apb_r  <= t_scaled + b_w;
          // With a zero denominator the flow passes straight through.
          if (d_zero) begin
            c0_r <= COEF_ONE;
            c1_r <= COEF_ZERO;
            c2_r <= COEF_ZERO;
          end
        end
        OP_LOAD_C0: begin
          rem_r  <= REM_W'(num_c0);
          neg_r  <= diff_r[DIV_W];
          q_r    <= '0;
          sat_r  <= 1'b0;
          dcnt_r <= DIV_STEPS;
        end
        OP_DIV_STEP: begin
          dcnt_r <= dcnt_r - DCNT_W'(1);
          if (div_first) begin
            sat_r <= ge;
          end else if (div_int) begin
            q_r   <= COEF_W'(ge);
            rem_r <= ge ? dsub[REM_W-1:0] : rem_r;
          end else if (div_rnd) begin
            q_r <= q_r + COEF_W'(ge);
          end else begin
            q_r   <= {q_r[COEF_W-2:0], ge};
            rem_r <= ge ? dsub[REM_W-1:0] : lhs[REM_W-1:0];
          end
        end
        OP_STORE_C0: begin
          c0_r   <= div_coef;
          rem_r  <= REM_W'(apb_r);
          neg_r  <= 1'b0;
          q_r    <= '0;
          sat_r  <= 1'b0;
          dcnt_r <= DIV_STEPS;
        end
        OP_STORE_C1: begin
          c1_r <= div_coef;
          c2_r <= coef_clamp(c2_sum);
        end
        OP_FIRST: begin
          routed_r <= inflow_r;
        end
        OP_MUL_C0: begin
          prod_r <= prod_w;
        end
        OP_MUL_C1: begin
          // The rounding half is folded in with the first product.
          acc_r  <= prod_r + ACC_W'(1 << (FRAC_W - 1));
          prod_r <= prod_w;
        end
        OP_MUL_C2: begin
          acc_r  <= acc_r + prod_r;
          prod_r <= prod_w;
        end
        OP_ACC: begin
          acc_r <= acc_r + prod_r;
        end
        OP_ROUND: begin
          routed_r <= flow_sat(acc_shr);
          clip_r   <= clip_r | flow_clip(acc_shr);
        end
        OP_OUTLET: begin
          if (!out_busy) begin
            out_data_r  <= flow_sat(ACC_W'(out_sum));
            out_user_r  <= clip_r | flow_clip(ACC_W'(out_sum));
            prev_in_r   <= inflow_r;
            prev_out_r  <= routed_r;
            start_r     <= last_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
